FILE: rtl/ptp_slave_offset_tracker_assert.svh
// assertion macros for the ptp slave offset tracker
// used by the top level; relies on clk and rst_n in the including module
`ifndef PTP_SLAVE_OFFSET_TRACKER_ASSERT_SVH
`define PTP_SLAVE_OFFSET_TRACKER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define PSOT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the condition
`define PSOT_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

FILE: rtl/ptp_sot_pkg.sv
// shared types, constants and helpers for the ptp slave offset tracker
// no dependencies
package ptp_sot_pkg;

    localparam int SEC_W   = 48;
    localparam int NS_W    = 30;
    localparam int TIME_W  = 64;
    localparam int CLOCK_W = 64;
    localparam int SEQ_W   = 16;
    localparam int DOM_W   = 8;
    localparam int MAC_W   = 48;
    localparam int SEC_HALF = SEC_W / 2;
    localparam int PROD_W   = SEC_HALF + NS_W;

    localparam logic [15:0]     PTP_ETHERTYPE  = 16'h88F7;
    localparam logic [3:0]      MSG_SYNC       = 4'h0;
    localparam logic [3:0]      MSG_FOLLOW_UP  = 4'h8;
    localparam logic [3:0]      MSG_DELAY_RESP = 4'h9;
    localparam logic [NS_W-1:0] NS_PER_SEC     = 30'd1000000000;
    localparam logic [15:0]     CLOCK_ID_FILL  = 16'hFFFE;

    localparam logic RESULT_DELAY_REQ = 1'b0;
    localparam logic RESULT_ADJUST    = 1'b1;

    // decoded kind of a transfer
    typedef enum logic [4:0] {
        KIND_NONE       = 5'b00001,
        KIND_TSTAMP     = 5'b00010,
        KIND_SYNC       = 5'b00100,
        KIND_FOLLOW_UP  = 5'b01000,
        KIND_DELAY_RESP = 5'b10000
    } msg_kind_t;

    // control fields of one item travelling down the pipe
    typedef struct packed {
        msg_kind_t          kind;
        logic [SEQ_W-1:0]   seq;
        logic [DOM_W-1:0]   domain;
        logic [CLOCK_W-1:0] source_clock;
        logic               req_is_me;
    } item_ctl_t;

    // decision result handed to the offset stage
    typedef struct packed {
        logic               kind;
        logic [SEQ_W-1:0]   seq;
        logic [DOM_W-1:0]   domain;
        logic [CLOCK_W-1:0] clock;
        logic [TIME_W-1:0]  d_sync;
        logic [TIME_W-1:0]  d_delay;
    } track_res_t;

    // local clock identity: mac[0..2], ff, fe, mac[3..5]
    function automatic logic [CLOCK_W-1:0] eui_identity(input logic [MAC_W-1:0] mac);
        eui_identity = {mac[MAC_W-1:MAC_W/2], CLOCK_ID_FILL, mac[MAC_W/2-1:0]};
    endfunction

endpackage

FILE: rtl/ptp_slave_offset_tracker.sv
// throughput: one item per cycle; input, stamp multiply, stamp add, state, offset
//   subtract and halving are one register stage each, stalling only on out_ready
// reset: rst_n clears local_mac, the master id, sequence ids, t1/t2/t3 and all valids
// depends on ptp_sot_pkg, ptp_sot_stamp, ptp_sot_track, ptp_sot_offset and ptp_slave_offset_tracker_assert.svh
module ptp_slave_offset_tracker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ptp_sot_pkg::MAC_W-1:0]         cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic [15:0]                           frame_ethertype,
    input  logic [3:0]                            message_code,
    input  logic [ptp_sot_pkg::SEQ_W-1:0]         seq_number,
    input  logic [ptp_sot_pkg::DOM_W-1:0]         domain,
    input  logic [ptp_sot_pkg::CLOCK_W-1:0]       source_clock,
    input  logic [ptp_sot_pkg::CLOCK_W-1:0]       requester_clock,
    input  logic [ptp_sot_pkg::SEC_W-1:0]         msg_stamp_sec,
    input  logic [ptp_sot_pkg::NS_W-1:0]          msg_stamp_ns,
    input  logic [ptp_sot_pkg::SEC_W-1:0]         local_stamp_sec,
    input  logic [ptp_sot_pkg::NS_W-1:0]          local_stamp_ns,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  result_kind,
    output logic [ptp_sot_pkg::SEQ_W-1:0]         request_seq,
    output logic [ptp_sot_pkg::DOM_W-1:0]         request_domain,
    output logic [ptp_sot_pkg::CLOCK_W-1:0]       request_clock,
    output logic signed [ptp_sot_pkg::TIME_W-1:0] offset_ns
);

    `include "ptp_slave_offset_tracker_assert.svh"

    logic [ptp_sot_pkg::MAC_W-1:0]     mac_reg;
    logic                              v0_reg;
    logic                              v1_reg;
    logic                              v2_reg;
    ptp_sot_pkg::item_ctl_t            ctl0_reg;
    ptp_sot_pkg::item_ctl_t            ctl1_reg;
    ptp_sot_pkg::item_ctl_t            ctl2_reg;
    logic [ptp_sot_pkg::SEC_W-1:0]     msg_sec_reg;
    logic [ptp_sot_pkg::NS_W-1:0]      msg_ns_reg;
    logic [ptp_sot_pkg::SEC_W-1:0]     loc_sec_reg;
    logic [ptp_sot_pkg::NS_W-1:0]      loc_ns_reg;

    logic [ptp_sot_pkg::CLOCK_W-1:0]   clock_me;
    ptp_sot_pkg::item_ctl_t            ctl0_next;
    logic                              en0;
    logic                              en1;
    logic                              en2;
    logic                              track_ready;
    logic                              track_valid;
    ptp_sot_pkg::track_res_t           track_res;
    logic                              offset_ready;
    logic                              mid_valid;
    logic [ptp_sot_pkg::TIME_W-1:0]    msg_total;
    logic [ptp_sot_pkg::TIME_W-1:0]    loc_total;

    assign clock_me = ptp_sot_pkg::eui_identity(mac_reg);

    // pipeline readiness, each stage fills any bubble ahead of it
    assign en2      = !v2_reg || track_ready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mac_reg <= cfg_wr_data;
        end
    end

    // decode the incoming transfer
    always_comb
    begin
        ctl0_next              = '0;
        ctl0_next.seq          = seq_number;
        ctl0_next.domain       = domain;
        ctl0_next.source_clock = source_clock;
        ctl0_next.req_is_me    = (requester_clock == clock_me);
        if (command)
        begin
            ctl0_next.kind = ptp_sot_pkg::KIND_TSTAMP;
        end
        else if (frame_ethertype != ptp_sot_pkg::PTP_ETHERTYPE)
        begin
            ctl0_next.kind = ptp_sot_pkg::KIND_NONE;
        end
        else
        begin
            case (message_code)
                ptp_sot_pkg::MSG_SYNC:       ctl0_next.kind = ptp_sot_pkg::KIND_SYNC;
                ptp_sot_pkg::MSG_FOLLOW_UP:  ctl0_next.kind = ptp_sot_pkg::KIND_FOLLOW_UP;
                ptp_sot_pkg::MSG_DELAY_RESP: ctl0_next.kind = ptp_sot_pkg::KIND_DELAY_RESP;
                default:                     ctl0_next.kind = ptp_sot_pkg::KIND_NONE;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= in_valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // input register and control pipeline
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            ctl0_reg    <= ctl0_next;
            msg_sec_reg <= msg_stamp_sec;
            msg_ns_reg  <= msg_stamp_ns;
            loc_sec_reg <= local_stamp_sec;
            loc_ns_reg  <= local_stamp_ns;
        end
        if (en1)
        begin
            ctl1_reg <= ctl0_reg;
        end
        if (en2)
        begin
            ctl2_reg <= ctl1_reg;
        end
    end

    // timestamp conversion for the message and local stamps
    ptp_sot_stamp u_msg_stamp (
        .clk    (clk),
        .load_a (en1),
        .load_b (en2),
        .sec    (msg_sec_reg),
        .ns     (msg_ns_reg),
        .total  (msg_total)
    );

    ptp_sot_stamp u_loc_stamp (
        .clk    (clk),
        .load_a (en1),
        .load_b (en2),
        .sec    (loc_sec_reg),
        .ns     (loc_ns_reg),
        .total  (loc_total)
    );

    // protocol state and decision
    ptp_sot_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (v2_reg),
        .item       (ctl2_reg),
        .msg_ns     (msg_total),
        .local_ns   (loc_total),
        .clock_me   (clock_me),
        .down_ready (offset_ready),
        .ready      (track_ready),
        .res_valid  (track_valid),
        .res        (track_res)
    );

    // offset arithmetic and result register
    ptp_sot_offset u_offset (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (track_valid),
        .res            (track_res),
        .ready          (offset_ready),
        .mid_valid      (mid_valid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .request_seq    (request_seq),
        .request_domain (request_domain),
        .request_clock  (request_clock),
        .offset_ns      (offset_ns)
    );

    // a result only appears when one was waiting in the offset stage
    `PSOT_ASSERT(a_out_from_mid, $rose(out_valid) |-> $past(mid_valid), "result without source")
    // delay request orders carry no offset
    `PSOT_ASSERT(a_req_no_offset, (out_valid && (result_kind == ptp_sot_pkg::RESULT_DELAY_REQ)) |-> (offset_ns == '0), "delay request with offset")
    // adjustments carry no sequence or domain
    `PSOT_ASSERT(a_adj_fields, (out_valid && (result_kind == ptp_sot_pkg::RESULT_ADJUST)) |-> ((request_seq == '0) && (request_domain == '0)), "adjustment with request fields")
    // an accepted transfer always lands in the input register
    `PSOT_ASSERT_NEXT(a_in_lands, in_valid && in_ready, v0_reg, "input transfer lost")

endmodule

FILE: rtl/ptp_sot_stamp.sv
// seconds/nanoseconds to 64-bit wrapping nanosecond count, two register stages
// depends on ptp_sot_pkg
module ptp_sot_stamp (
    input  logic                              clk,
    input  logic                              load_a,
    input  logic                              load_b,
    input  logic [ptp_sot_pkg::SEC_W-1:0]     sec,
    input  logic [ptp_sot_pkg::NS_W-1:0]      ns,
    output logic [ptp_sot_pkg::TIME_W-1:0]    total
);

    logic [ptp_sot_pkg::PROD_W-1:0]   prod_hi_reg;
    logic [ptp_sot_pkg::PROD_W-1:0]   prod_lo_reg;
    logic [ptp_sot_pkg::NS_W-1:0]     ns_reg;
    logic [ptp_sot_pkg::TIME_W-1:0]   total_reg;
    logic [ptp_sot_pkg::PROD_W-1:0]   prod_hi_next;
    logic [ptp_sot_pkg::PROD_W-1:0]   prod_lo_next;
    logic [ptp_sot_pkg::PROD_W+ptp_sot_pkg::SEC_HALF-1:0] hi_shift;
    logic [ptp_sot_pkg::TIME_W-1:0]   total_next;

    // split seconds into two halves, one constant multiply each
    always_comb
    begin
        prod_hi_next = {{ptp_sot_pkg::NS_W{1'b0}}, sec[ptp_sot_pkg::SEC_W-1:ptp_sot_pkg::SEC_HALF]}
                     * {{ptp_sot_pkg::SEC_HALF{1'b0}}, ptp_sot_pkg::NS_PER_SEC};
        prod_lo_next = {{ptp_sot_pkg::NS_W{1'b0}}, sec[ptp_sot_pkg::SEC_HALF-1:0]}
                     * {{ptp_sot_pkg::SEC_HALF{1'b0}}, ptp_sot_pkg::NS_PER_SEC};
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            ns_reg      <= ns;
        end
    end

    // recombine partial products and add nanoseconds, wrapping at 64 bits
    always_comb
    begin
        hi_shift   = {prod_hi_reg, {ptp_sot_pkg::SEC_HALF{1'b0}}};
        total_next = hi_shift[ptp_sot_pkg::TIME_W-1:0]
                   + {{(ptp_sot_pkg::TIME_W-ptp_sot_pkg::PROD_W){1'b0}}, prod_lo_reg}
                   + {{(ptp_sot_pkg::TIME_W-ptp_sot_pkg::NS_W){1'b0}}, ns_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

FILE: rtl/ptp_sot_track.sv
// protocol state (master id, sequence ids, t1/t2/t3) and per-message decision
// depends on ptp_sot_pkg
module ptp_sot_track (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  ptp_sot_pkg::item_ctl_t            item,
    input  logic [ptp_sot_pkg::TIME_W-1:0]    msg_ns,
    input  logic [ptp_sot_pkg::TIME_W-1:0]    local_ns,
    input  logic [ptp_sot_pkg::CLOCK_W-1:0]   clock_me,
    input  logic                              down_ready,
    output logic                              ready,
    output logic                              res_valid,
    output ptp_sot_pkg::track_res_t           res
);

    logic                              master_known_reg;
    logic [ptp_sot_pkg::CLOCK_W-1:0]   master_id_reg;
    logic [ptp_sot_pkg::SEQ_W-1:0]     sync_seq_reg;
    logic [ptp_sot_pkg::SEQ_W-1:0]     followup_seq_reg;
    logic [ptp_sot_pkg::TIME_W-1:0]    t1_reg;
    logic [ptp_sot_pkg::TIME_W-1:0]    t2_reg;
    logic [ptp_sot_pkg::TIME_W-1:0]    t3_reg;
    logic                              res_valid_reg;
    ptp_sot_pkg::track_res_t           res_reg;

    logic                              master_known_next;
    logic [ptp_sot_pkg::CLOCK_W-1:0]   master_id_next;
    logic [ptp_sot_pkg::SEQ_W-1:0]     sync_seq_next;
    logic [ptp_sot_pkg::SEQ_W-1:0]     followup_seq_next;
    logic [ptp_sot_pkg::TIME_W-1:0]    t1_next;
    logic [ptp_sot_pkg::TIME_W-1:0]    t2_next;
    logic [ptp_sot_pkg::TIME_W-1:0]    t3_next;
    logic                              emit;
    logic                              step;
    logic [ptp_sot_pkg::CLOCK_W-1:0]   master_eff;
    ptp_sot_pkg::track_res_t           res_next;

    assign ready = !res_valid_reg || down_ready;
    assign step  = item_valid && ready;

    // message handling; state only moves when the item leaves this stage
    always_comb
    begin
        master_known_next = master_known_reg;
        master_id_next    = master_id_reg;
        sync_seq_next     = sync_seq_reg;
        followup_seq_next = followup_seq_reg;
        t1_next           = t1_reg;
        t2_next           = t2_reg;
        t3_next           = t3_reg;
        emit              = 1'b0;
        master_eff        = master_known_reg ? master_id_reg : item.source_clock;
        res_next          = '0;
        res_next.clock    = clock_me;
        case (item.kind)
            ptp_sot_pkg::KIND_TSTAMP:
            begin
                t3_next = local_ns;
            end
            ptp_sot_pkg::KIND_SYNC:
            begin
                sync_seq_next     = item.seq;
                master_known_next = 1'b1;
                master_id_next    = master_eff;
                if (item.source_clock == master_eff)
                begin
                    t2_next = local_ns;
                end
            end
            ptp_sot_pkg::KIND_FOLLOW_UP:
            begin
                if (item.source_clock == master_id_reg)
                begin
                    followup_seq_next = item.seq;
                    t1_next           = msg_ns;
                    if (item.seq == sync_seq_reg)
                    begin
                        t3_next         = '0;
                        emit            = 1'b1;
                        res_next.kind   = ptp_sot_pkg::RESULT_DELAY_REQ;
                        res_next.seq    = item.seq;
                        res_next.domain = item.domain;
                    end
                end
            end
            ptp_sot_pkg::KIND_DELAY_RESP:
            begin
                if (item.req_is_me && (item.seq == followup_seq_reg))
                begin
                    emit             = 1'b1;
                    res_next.kind    = ptp_sot_pkg::RESULT_ADJUST;
                    res_next.d_sync  = t2_reg - t1_reg;
                    res_next.d_delay = msg_ns - t3_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_known_reg <= 1'b0;
            master_id_reg    <= '0;
            sync_seq_reg     <= '0;
            followup_seq_reg <= '0;
            t1_reg           <= '0;
            t2_reg           <= '0;
            t3_reg           <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                master_known_reg <= master_known_next;
                master_id_reg    <= master_id_next;
                sync_seq_reg     <= sync_seq_next;
                followup_seq_reg <= followup_seq_next;
                t1_reg           <= t1_next;
                t2_reg           <= t2_next;
                t3_reg           <= t3_next;
            end
            if (ready)
            begin
                res_valid_reg <= item_valid && emit;
            end
        end
    end

    // decision payload
    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/ptp_sot_offset.sv
// offset arithmetic: negated difference, halved toward zero, and output register
// depends on ptp_sot_pkg
module ptp_sot_offset (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  res_valid,
    input  ptp_sot_pkg::track_res_t               res,
    output logic                                  ready,
    output logic                                  mid_valid,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  result_kind,
    output logic [ptp_sot_pkg::SEQ_W-1:0]         request_seq,
    output logic [ptp_sot_pkg::DOM_W-1:0]         request_domain,
    output logic [ptp_sot_pkg::CLOCK_W-1:0]       request_clock,
    output logic signed [ptp_sot_pkg::TIME_W-1:0] offset_ns
);

    logic                              mid_valid_reg;
    logic                              mid_kind_reg;
    logic [ptp_sot_pkg::SEQ_W-1:0]     mid_seq_reg;
    logic [ptp_sot_pkg::DOM_W-1:0]     mid_domain_reg;
    logic [ptp_sot_pkg::CLOCK_W-1:0]   mid_clock_reg;
    logic [ptp_sot_pkg::TIME_W-1:0]    neg_reg;
    logic                              out_valid_reg;
    logic                              kind_reg;
    logic [ptp_sot_pkg::SEQ_W-1:0]     seq_reg;
    logic [ptp_sot_pkg::DOM_W-1:0]     domain_reg;
    logic [ptp_sot_pkg::CLOCK_W-1:0]   clock_reg;
    logic [ptp_sot_pkg::TIME_W-1:0]    offset_reg;

    logic                              out_load;
    logic                              mid_load;
    logic [ptp_sot_pkg::TIME_W-1:0]    neg_next;
    logic [ptp_sot_pkg::TIME_W-1:0]    round_sum;
    logic [ptp_sot_pkg::TIME_W-1:0]    offset_next;

    assign out_load = !out_valid_reg || out_ready;
    assign mid_load = !mid_valid_reg || out_load;
    assign ready    = mid_load;

    // -(d_sync - d_delay) is d_delay - d_sync
    assign neg_next = res.d_delay - res.d_sync;

    // truncating halve: add one when negative, then arithmetic shift
    always_comb
    begin
        round_sum   = neg_reg + {{(ptp_sot_pkg::TIME_W-1){1'b0}}, neg_reg[ptp_sot_pkg::TIME_W-1]};
        offset_next = {round_sum[ptp_sot_pkg::TIME_W-1], round_sum[ptp_sot_pkg::TIME_W-1:1]};
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mid_load)
            begin
                mid_valid_reg <= res_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (mid_load)
        begin
            mid_kind_reg   <= res.kind;
            mid_seq_reg    <= res.seq;
            mid_domain_reg <= res.domain;
            mid_clock_reg  <= res.clock;
            neg_reg        <= neg_next;
        end
        if (out_load)
        begin
            kind_reg   <= mid_kind_reg;
            seq_reg    <= mid_seq_reg;
            domain_reg <= mid_domain_reg;
            clock_reg  <= mid_clock_reg;
            offset_reg <= offset_next;
        end
    end

    assign mid_valid      = mid_valid_reg;
    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign request_seq    = seq_reg;
    assign request_domain = domain_reg;
    assign request_clock  = clock_reg;
    assign offset_ns      = offset_reg;

endmodule

FILE: tb/ptp_slave_offset_tracker_checker.sv
`timescale 1ns / 1ps
// scoreboard for the ptp slave offset tracker: watches both transfer channels,
// predicts each result from the accepted frames and compares it field by field
// depends on ptp_sot_pkg for widths, message codes and result kinds
module ptp_slave_offset_tracker_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ptp_sot_pkg::MAC_W-1:0]         cfg_wr_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  command,
    input  logic [15:0]                           frame_ethertype,
    input  logic [3:0]                            message_code,
    input  logic [ptp_sot_pkg::SEQ_W-1:0]         seq_number,
    input  logic [ptp_sot_pkg::DOM_W-1:0]         domain,
    input  logic [ptp_sot_pkg::CLOCK_W-1:0]       source_clock,
    input  logic [ptp_sot_pkg::CLOCK_W-1:0]       requester_clock,
    input  logic [ptp_sot_pkg::SEC_W-1:0]         msg_stamp_sec,
    input  logic [ptp_sot_pkg::NS_W-1:0]          msg_stamp_ns,
    input  logic [ptp_sot_pkg::SEC_W-1:0]         local_stamp_sec,
    input  logic [ptp_sot_pkg::NS_W-1:0]          local_stamp_ns,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic                                  result_kind,
    input  logic [ptp_sot_pkg::SEQ_W-1:0]         request_seq,
    input  logic [ptp_sot_pkg::DOM_W-1:0]         request_domain,
    input  logic [ptp_sot_pkg::CLOCK_W-1:0]       request_clock,
    input  logic signed [ptp_sot_pkg::TIME_W-1:0] offset_ns,
    output int                                    error_count,
    output int                                    results_owed,
    output int                                    delay_req_seen,
    output int                                    adjust_seen
);
    import ptp_sot_pkg::*;

    localparam logic CMD_TX_STAMP = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [SEQ_W-1:0]   seq;
        logic [DOM_W-1:0]   domain;
        logic [CLOCK_W-1:0] clock;
        logic [TIME_W-1:0]  offset;
    } ptp_result_t;

    // shadow of the tracker state
    logic [MAC_W-1:0]   port_mac;
    logic               master_locked;
    logic [CLOCK_W-1:0] master_clock;
    logic [SEQ_W-1:0]   sync_seq_seen;
    logic [SEQ_W-1:0]   follow_seq_seen;
    logic [TIME_W-1:0]  origin_ns;
    logic [TIME_W-1:0]  sync_rx_ns;
    logic [TIME_W-1:0]  req_tx_ns;
    ptp_result_t        awaited_results[$];
    ptp_result_t        head;

    // seconds and nanoseconds folded into one wrapping nanosecond count
    function automatic logic [TIME_W-1:0] stamp_ns(input logic [SEC_W-1:0] sec,
                                                   input logic [NS_W-1:0]  ns);
        return TIME_W'(sec) * TIME_W'(NS_PER_SEC) + TIME_W'(ns);
    endfunction

    // eui-64 style identity built from the port mac
    function automatic logic [CLOCK_W-1:0] port_identity(input logic [MAC_W-1:0] mac);
        logic [CLOCK_W-1:0] upper;
        logic [CLOCK_W-1:0] lower;
        upper = CLOCK_W'(mac >> 24) << 40;
        lower = CLOCK_W'(mac & 48'hFF_FFFF);
        return upper | (CLOCK_W'(CLOCK_ID_FILL) << 24) | lower;
    endfunction

    // negate the wrapped difference, then halve toward zero
    function automatic logic [TIME_W-1:0] halve_negated(input logic [TIME_W-1:0] diff);
        logic signed [TIME_W-1:0] neg;
        neg = -diff;
        return neg / 64'sd2;
    endfunction

    // update the shadow state for one accepted frame and queue any result it produces
    task automatic track_ptp_frame();
        logic [TIME_W-1:0]  msg_ns;
        logic [TIME_W-1:0]  local_ns;
        logic [CLOCK_W-1:0] me;
        ptp_result_t        res;
        msg_ns   = stamp_ns(msg_stamp_sec, msg_stamp_ns);
        local_ns = stamp_ns(local_stamp_sec, local_stamp_ns);
        me       = port_identity(port_mac);
        if (command == CMD_TX_STAMP)
            req_tx_ns = local_ns;
        else if (frame_ethertype == PTP_ETHERTYPE)
        begin
            case (message_code)
                MSG_SYNC:
                begin
                    sync_seq_seen = seq_number;
                    if (!master_locked)
                    begin
                        master_clock  = source_clock;
                        master_locked = 1'b1;
                    end
                    if (source_clock == master_clock)
                        sync_rx_ns = local_ns;
                end
                MSG_FOLLOW_UP:
                begin
                    if (source_clock == master_clock)
                    begin
                        follow_seq_seen = seq_number;
                        origin_ns       = msg_ns;
                        if (follow_seq_seen == sync_seq_seen)
                        begin
                            req_tx_ns  = '0;
                            res.kind   = RESULT_DELAY_REQ;
                            res.seq    = sync_seq_seen;
                            res.domain = domain;
                            res.clock  = me;
                            res.offset = '0;
                            awaited_results.push_back(res);
                        end
                    end
                end
                MSG_DELAY_RESP:
                begin
                    if (requester_clock == me && seq_number == follow_seq_seen)
                    begin
                        res.kind   = RESULT_ADJUST;
                        res.seq    = '0;
                        res.domain = '0;
                        res.clock  = me;
                        res.offset = halve_negated((sync_rx_ns - origin_ns)
                                                   - (msg_ns - req_tx_ns));
                        awaited_results.push_back(res);
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // both channels sampled on the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_mac        = '0;
            master_locked   = 1'b0;
            master_clock    = '0;
            sync_seq_seen   = '0;
            follow_seq_seen = '0;
            origin_ns       = '0;
            sync_rx_ns      = '0;
            req_tx_ns       = '0;
            awaited_results.delete();
            error_count     = 0;
            results_owed    = 0;
            delay_req_seen  = 0;
            adjust_seen     = 0;
        end
        else
        begin
            // result transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result transfer: result_kind %0d offset_ns %0d",
                           result_kind, offset_ns);
                    error_count++;
                end
                else
                begin
                    head = awaited_results.pop_front();
                    if (result_kind !== head.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", head.kind, result_kind);
                        error_count++;
                    end
                    if (request_seq !== head.seq)
                    begin
                        $error("request_seq: expected %h, got %h", head.seq, request_seq);
                        error_count++;
                    end
                    if (request_domain !== head.domain)
                    begin
                        $error("request_domain: expected %h, got %h",
                               head.domain, request_domain);
                        error_count++;
                    end
                    if (request_clock !== head.clock)
                    begin
                        $error("request_clock: expected %h, got %h",
                               head.clock, request_clock);
                        error_count++;
                    end
                    if (offset_ns !== head.offset)
                    begin
                        $error("offset_ns: expected %0d, got %0d",
                               $signed(head.offset), offset_ns);
                        error_count++;
                    end
                    if (head.kind == RESULT_ADJUST)
                        adjust_seen++;
                    else
                        delay_req_seen++;
                end
            end

            if (cfg_wr_en)
                port_mac = cfg_wr_data;

            if (in_valid && in_ready)
                track_ptp_frame();

            results_owed = awaited_results.size();
        end
    end

endmodule

FILE: tb/ptp_slave_offset_tracker_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the ptp slave offset tracker: directed exchanges, then
// random two-step exchanges and noise under three handshake profiles and mac settings
// depends on ptp_sot_pkg, the tracker rtl and ptp_slave_offset_tracker_checker
module ptp_slave_offset_tracker_tb;
    import ptp_sot_pkg::*;

    localparam logic CMD_RX_FRAME = 1'b0;
    localparam logic CMD_TX_STAMP = 1'b1;
    localparam int   RANDOM_ITEMS = 1400;
    localparam int   PIPE_SETTLE  = 12;
    localparam logic [CLOCK_W-1:0] MASTER_CLOCK = {CLOCK_W{1'b1}};

    typedef struct {
        logic               command;
        logic [15:0]        ethertype;
        logic [3:0]         code;
        logic [SEQ_W-1:0]   seq;
        logic [DOM_W-1:0]   domain;
        logic [CLOCK_W-1:0] source;
        logic [CLOCK_W-1:0] requester;
        logic [SEC_W-1:0]   msg_sec;
        logic [NS_W-1:0]    msg_ns;
        logic [SEC_W-1:0]   local_sec;
        logic [NS_W-1:0]    local_ns;
    } ptp_frame_t;

    typedef enum int {
        FLAW_STRANGER_SYNC,
        FLAW_SEQ_SLIP,
        FLAW_NO_STAMP,
        FLAW_FOREIGN_RESP,
        FLAW_STALE_RESP,
        FLAW_NONE
    } exchange_flaw_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [MAC_W-1:0]      cfg_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  command;
    logic [15:0]           frame_ethertype;
    logic [3:0]            message_code;
    logic [SEQ_W-1:0]      seq_number;
    logic [DOM_W-1:0]      domain;
    logic [CLOCK_W-1:0]    source_clock;
    logic [CLOCK_W-1:0]    requester_clock;
    logic [SEC_W-1:0]      msg_stamp_sec;
    logic [NS_W-1:0]       msg_stamp_ns;
    logic [SEC_W-1:0]      local_stamp_sec;
    logic [NS_W-1:0]       local_stamp_ns;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  result_kind;
    logic [SEQ_W-1:0]      request_seq;
    logic [DOM_W-1:0]      request_domain;
    logic [CLOCK_W-1:0]    request_clock;
    logic signed [TIME_W-1:0] offset_ns;

    int                    error_count;
    int                    results_owed;
    int                    delay_req_seen;
    int                    adjust_seen;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    frames_sent;
    int                    mac_settings;
    logic [MAC_W-1:0]      mac_now;
    ptp_frame_t            f;

    ptp_slave_offset_tracker dut (.*);

    ptp_slave_offset_tracker_checker checker_i (.*);

    // 2 ns clock
    always #1 clk = ~clk;

    // receiver stalls at the current rate
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [SEC_W-1:0] rand_sec();
        return SEC_W'({$urandom, $urandom});
    endfunction

    // mostly legal nanoseconds, sometimes the full field
    function automatic logic [NS_W-1:0] rand_ns();
        if ($urandom_range(7) == 0)
            return NS_W'($urandom);
        return NS_W'($urandom_range(999999999));
    endfunction

    // seconds close to the exchange base, now and then anywhere
    function automatic logic [SEC_W-1:0] jitter_sec(input logic [SEC_W-1:0] base);
        if ($urandom_range(3) == 0)
            return rand_sec();
        return base + SEC_W'($urandom_range(2));
    endfunction

    function automatic logic [CLOCK_W-1:0] port_id(input logic [MAC_W-1:0] mac);
        return {mac[MAC_W-1:24], CLOCK_ID_FILL, mac[23:0]};
    endfunction

    function automatic ptp_frame_t rand_frame();
        ptp_frame_t r;
        r.command    = CMD_RX_FRAME;
        r.ethertype  = 16'($urandom);
        r.code       = 4'($urandom);
        r.seq        = SEQ_W'($urandom);
        r.domain     = DOM_W'($urandom);
        r.source     = {$urandom, $urandom};
        r.requester  = {$urandom, $urandom};
        r.msg_sec    = rand_sec();
        r.msg_ns     = rand_ns();
        r.local_sec  = rand_sec();
        r.local_ns   = rand_ns();
        return r;
    endfunction

    function automatic ptp_frame_t ptp_msg(input logic [3:0]         kind,
                                           input logic [CLOCK_W-1:0] src,
                                           input logic [SEQ_W-1:0]   seq);
        ptp_frame_t r;
        r           = rand_frame();
        r.ethertype = PTP_ETHERTYPE;
        r.code      = kind;
        r.source    = src;
        r.seq       = seq;
        return r;
    endfunction

    // transmit timestamp report; all other fields are don't-care
    function automatic ptp_frame_t tx_report(input logic [SEC_W-1:0] sec,
                                             input logic [NS_W-1:0]  ns);
        ptp_frame_t r;
        r           = rand_frame();
        r.command   = CMD_TX_STAMP;
        r.local_sec = sec;
        r.local_ns  = ns;
        return r;
    endfunction

    // one input transfer, with a random gap in front
    task automatic send_frame(input ptp_frame_t fr);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command         <= fr.command;
        frame_ethertype <= fr.ethertype;
        message_code    <= fr.code;
        seq_number      <= fr.seq;
        domain          <= fr.domain;
        source_clock    <= fr.source;
        requester_clock <= fr.requester;
        msg_stamp_sec   <= fr.msg_sec;
        msg_stamp_ns    <= fr.msg_ns;
        local_stamp_sec <= fr.local_sec;
        local_stamp_ns  <= fr.local_ns;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // only frames that can touch the tracker state count toward the total
        if (fr.command == CMD_TX_STAMP || (fr.ethertype == PTP_ETHERTYPE &&
            (fr.code == MSG_SYNC || fr.code == MSG_FOLLOW_UP ||
             fr.code == MSG_DELAY_RESP)))
            frames_sent++;
    endtask

    // hold the sender until every result is out, let the pipe empty, then write the mac
    task automatic settle_and_set_mac(input logic [MAC_W-1:0] mac);
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
        cfg_wr_data <= mac;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mac_now = mac;
        mac_settings++;
    endtask

    // sync, follow up, timestamp report, delay response, occasionally broken
    task automatic run_exchange();
        logic [SEQ_W-1:0] s;
        logic [SEC_W-1:0] base;
        exchange_flaw_t   flaw;
        ptp_frame_t       fr;
        s    = SEQ_W'($urandom);
        base = rand_sec();
        if ($urandom_range(99) < 70)
            flaw = FLAW_NONE;
        else
            flaw = exchange_flaw_t'($urandom_range(FLAW_STALE_RESP));

        fr = ptp_msg(MSG_SYNC, (flaw == FLAW_STRANGER_SYNC) ? {$urandom, $urandom}
                                                           : MASTER_CLOCK, s);
        fr.local_sec = jitter_sec(base);
        send_frame(fr);

        fr = ptp_msg(MSG_FOLLOW_UP, MASTER_CLOCK, (flaw == FLAW_SEQ_SLIP) ? s + 1'b1 : s);
        fr.msg_sec = jitter_sec(base);
        send_frame(fr);

        if (flaw != FLAW_NO_STAMP)
            send_frame(tx_report(jitter_sec(base), rand_ns()));

        fr = ptp_msg(MSG_DELAY_RESP, {$urandom, $urandom},
                     (flaw == FLAW_STALE_RESP) ? s ^ 16'h8000 : s);
        fr.requester = (flaw == FLAW_FOREIGN_RESP) ? {$urandom, $urandom} : port_id(mac_now);
        fr.msg_sec   = jitter_sec(base);
        send_frame(fr);
    endtask

    // mostly well-formed exchanges, the rest noise
    task automatic run_mix(input int target);
        ptp_frame_t fr;
        while (frames_sent < target)
        begin
            if ($urandom_range(99) < 75)
                run_exchange();
            else
            begin
                fr = rand_frame();
                if ($urandom_range(3) != 0)
                    fr.ethertype = PTP_ETHERTYPE;
                case ($urandom_range(3))
                    0: fr.code = MSG_SYNC;
                    1: fr.code = MSG_FOLLOW_UP;
                    2: fr.code = MSG_DELAY_RESP;
                    default: fr.code = 4'($urandom);
                endcase
                if ($urandom_range(7) == 0)
                    fr.command = CMD_TX_STAMP;
                if ($urandom_range(3) == 0)
                    fr.requester = port_id(mac_now);
                send_frame(fr);
            end
        end
    endtask

    // main sequence
    initial
    begin
        int base_count;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        command         = CMD_RX_FRAME;
        frame_ethertype = '0;
        message_code    = MSG_SYNC;
        seq_number      = '0;
        domain          = '0;
        source_clock    = '0;
        requester_clock = '0;
        msg_stamp_sec   = '0;
        msg_stamp_ns    = '0;
        local_stamp_sec = '0;
        local_stamp_ns  = '0;
        send_idle_pct   = 23;
        recv_idle_pct   = 59;
        frames_sent     = 0;
        mac_settings    = 0;
        mac_now         = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // follow up before any sync matches the cleared master id and sequence
        f = ptp_msg(MSG_FOLLOW_UP, '0, '0);
        f.domain  = 8'hFF;
        f.msg_sec = {SEC_W{1'b1}};
        f.msg_ns  = NS_W'(999999999);
        send_frame(f);
        // timestamp report with seconds, nanoseconds and ethertype at their top, ns beyond one second
        f = tx_report({SEC_W{1'b1}}, {NS_W{1'b1}});
        f.ethertype = 16'hFFFF;
        send_frame(f);
        // delay response addressed to the reset mac identity
        f = ptp_msg(MSG_DELAY_RESP, '0, '0);
        f.requester = port_id('0);
        f.msg_sec   = '0;
        f.msg_ns    = '0;
        send_frame(f);
        // response for another clock, then one with the wrong sequence
        f = ptp_msg(MSG_DELAY_RESP, '0, '0);
        f.requester = port_id('0) ^ 64'h1;
        send_frame(f);
        f = ptp_msg(MSG_DELAY_RESP, '0, 16'h0001);
        f.requester = port_id('0);
        send_frame(f);
        // foreign ethertypes and an unknown message type change nothing
        f = ptp_msg(MSG_SYNC, MASTER_CLOCK, 16'h7777);
        f.ethertype = 16'h0000;
        send_frame(f);
        f.ethertype = 16'hFFFF;
        send_frame(f);
        f = ptp_msg(4'hF, MASTER_CLOCK, 16'h7777);
        send_frame(f);
        // first sync latches the master; t2 of exactly 2^63 ns
        f = ptp_msg(MSG_SYNC, MASTER_CLOCK, 16'hFFFF);
        f.local_sec = SEC_W'(64'd9223372036);
        f.local_ns  = NS_W'(854775808);
        send_frame(f);
        // sync from a stranger with the same sequence does not touch t2
        f = ptp_msg(MSG_SYNC, '0, 16'hFFFF);
        send_frame(f);
        // follow up from a stranger is dropped
        f = ptp_msg(MSG_FOLLOW_UP, '0, 16'hFFFF);
        send_frame(f);
        // matching follow up with t1 at zero, then response with t4 at zero:
        // the most negative difference halves to -2^62
        f = ptp_msg(MSG_FOLLOW_UP, MASTER_CLOCK, 16'hFFFF);
        f.domain  = 8'h00;
        f.msg_sec = '0;
        f.msg_ns  = '0;
        send_frame(f);
        f = ptp_msg(MSG_DELAY_RESP, {$urandom, $urandom}, 16'hFFFF);
        f.requester = port_id('0);
        f.msg_sec   = '0;
        f.msg_ns    = '0;
        send_frame(f);
        // a second response for the same exchange after a new t3
        send_frame(tx_report(SEC_W'(1), '0));
        f.msg_sec = SEC_W'(1);
        f.msg_ns  = NS_W'(500);
        send_frame(f);

        // all-ones mac, then a small clean exchange
        settle_and_set_mac({MAC_W{1'b1}});
        f = ptp_msg(MSG_SYNC, MASTER_CLOCK, '0);
        f.local_sec = SEC_W'(100);
        f.local_ns  = NS_W'(250);
        send_frame(f);
        f = ptp_msg(MSG_FOLLOW_UP, MASTER_CLOCK, '0);
        f.domain  = 8'h5A;
        f.msg_sec = SEC_W'(100);
        f.msg_ns  = '0;
        send_frame(f);
        send_frame(tx_report(SEC_W'(100), NS_W'(1000)));
        f = ptp_msg(MSG_DELAY_RESP, '0, '0);
        f.requester = port_id(mac_now);
        f.msg_sec   = SEC_W'(100);
        f.msg_ns    = NS_W'(1500);
        send_frame(f);

        // random phases: sender light, receiver heavy; then swapped; then no idling
        base_count = frames_sent;
        settle_and_set_mac(MAC_W'({$urandom, $urandom}));
        run_mix(base_count + RANDOM_ITEMS / 3);

        settle_and_set_mac('0);
        send_idle_pct = 59;
        recv_idle_pct = 23;
        run_mix(base_count + 2 * RANDOM_ITEMS / 3);

        settle_and_set_mac(MAC_W'({$urandom, $urandom}));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_mix(base_count + RANDOM_ITEMS);

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);

        $display("run: %0d state-changing frames, %0d mac settings, three handshake profiles",
                 frames_sent, mac_settings);
        $display("run: %0d delay request orders and %0d offsets compared",
                 delay_req_seen, adjust_seen);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("watchdog expired with %0d results outstanding", results_owed);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ptp_sot_pkg.sv
rtl/ptp_sot_stamp.sv
rtl/ptp_sot_track.sv
rtl/ptp_sot_offset.sv
rtl/ptp_slave_offset_tracker.sv
tb/ptp_slave_offset_tracker_checker.sv
tb/ptp_slave_offset_tracker_tb.sv
